FILE: rtl/core/mhb_pkg.sv
// shared constants and types for the min-heap builder
`default_nettype none
package mhb_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int CAPACITY_DEF = 16;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SWAP    = 2'd0,
    KIND_ELEM    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

endpackage
`default_nettype wire

FILE: rtl/core/min_heap_builder.sv
// top level: collects elements into a ram, heapifies bottom-up, streams results
// Elements are taken one per cycle while busy_o is low; the element with
// final_item_i set starts the build, and busy_o stays high until the verdict
// has gone out. The build visits nodes n/2-1 down to 0 in a one-write,
// one-read-port ram: each sift level reads the node, the left child and the
// right child, then compares, plus a write-back of the child slot when an
// exchange happens. The heap dump then streams the n elements, and the
// verdict follows. Every result is shown for exactly one cycle with strobe_o
// high and must be taken then; the receiver cannot stall it. Elements beyond
// CAPACITY are dropped and reported in the verdict.
`default_nettype none
module min_heap_builder #(
  parameter int CAPACITY = mhb_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [mhb_pkg::DATA_W-1:0] value_i,
  input  wire logic                              final_item_i,
  output logic                                   strobe_o,
  output logic             [mhb_pkg::KIND_W-1:0] kind_o,
  output logic signed      [mhb_pkg::DATA_W-1:0] first_value_o,
  output logic signed      [mhb_pkg::DATA_W-1:0] second_value_o,
  output logic                                   already_heap_o,
  output logic                                   overflowed_o,
  output logic                                   final_result_o
);

  import mhb_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = AW + 2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_NODE,
    S_LEFT,
    S_RIGHT,
    S_CMP,
    S_WR,
    S_EMIT0,
    S_EMIT
  } state_e;

  state_e                    state_q;
  logic                      in_verdict_q;
  logic [CntW-1:0]           count_q;
  logic [CntW-1:0]           n_q;
  logic [AW-1:0]             root_q;
  logic [AW-1:0]             node_q;
  logic [AW-1:0]             pick_q;
  logic [AW-1:0]             idx_q;
  logic signed [DATA_W-1:0]  pv_q;
  logic signed [DATA_W-1:0]  lv_q;
  logic                      any_swap_q;
  logic                      ovf_q;

  logic                      strobe_q;
  logic [KIND_W-1:0]         kind_q;
  logic signed [DATA_W-1:0]  first_q;
  logic signed [DATA_W-1:0]  second_q;
  logic                      heap_q;
  logic                      ovf_out_q;
  logic                      fin_q;

  // ram port
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [DATA_W-1:0]         wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic [DATA_W-1:0]         rdata;
  logic signed [DATA_W-1:0]  rv;

  logic                      full;
  logic [CntW-1:0]           n_next;
  logic [CntW-1:0]           half;
  logic [IdxW-1:0]           left_idx;
  logic [IdxW-1:0]           right_idx;
  logic                      left_in;
  logic                      right_in;
  logic                      lt_left;
  logic                      lt_right;
  logic signed [DATA_W-1:0]  min_left;
  logic signed [DATA_W-1:0]  min_val;
  logic [AW-1:0]             pick;
  logic                      swap;
  logic                      emit_last;

  mhb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rv        = $signed(rdata);
  assign full      = (count_q == CntW'(CAPACITY));
  assign n_next    = full ? count_q : count_q + 1'b1;
  assign half      = n_next >> 1;
  assign left_idx  = IdxW'({node_q, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign left_in   = left_idx < IdxW'(n_q);
  assign right_in  = right_idx < IdxW'(n_q);

  // strictly smaller child wins, left kept on a tie
  assign lt_left   = left_in && (lv_q < pv_q);
  assign min_left  = lt_left ? lv_q : pv_q;
  assign lt_right  = right_in && (rv < min_left);
  assign min_val   = lt_right ? rv : min_left;
  assign pick      = lt_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign swap      = lt_left || lt_right;
  assign emit_last = (CntW'(idx_q) + 1'b1) == n_q;

  always_comb begin
    we    = 1'b0;
    waddr = node_q;
    wdata = pv_q;
    re    = 1'b0;
    raddr = node_q;
    unique case (state_q)
      S_LOAD: begin
        we    = start_i && !in_verdict_q && !full;
        waddr = count_q[AW-1:0];
        wdata = value_i;
      end
      S_NODE: begin
        re    = 1'b1;
        raddr = node_q;
      end
      S_LEFT: begin
        re    = left_in;
        raddr = left_idx[AW-1:0];
      end
      S_RIGHT: begin
        re    = right_in;
        raddr = right_idx[AW-1:0];
      end
      S_CMP: begin
        we    = swap;
        waddr = node_q;
        wdata = min_val;
      end
      S_WR: begin
        we    = 1'b1;
        waddr = pick_q;
        wdata = pv_q;
      end
      S_EMIT0: begin
        re    = 1'b1;
        raddr = '0;
      end
      S_EMIT: begin
        re    = !emit_last;
        raddr = idx_q + 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      in_verdict_q <= 1'b0;
      count_q      <= '0;
      n_q          <= '0;
      root_q       <= '0;
      node_q       <= '0;
      pick_q       <= '0;
      idx_q        <= '0;
      pv_q         <= '0;
      lv_q         <= '0;
      any_swap_q   <= 1'b0;
      ovf_q        <= 1'b0;
      strobe_q     <= 1'b0;
      kind_q       <= KIND_SWAP;
      first_q      <= '0;
      second_q     <= '0;
      heap_q       <= 1'b0;
      ovf_out_q    <= 1'b0;
      fin_q        <= 1'b0;
    end else begin
      strobe_q     <= 1'b0;
      in_verdict_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (in_verdict_q) begin
            // nothing accepted in the verdict cycle; busy is still high
          end else if (start_i) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + 1'b1;
            end
            if (final_item_i) begin
              n_q <= n_next;
              if (half == '0) begin
                state_q <= S_EMIT0;
              end else begin
                root_q  <= AW'(half - 1'b1);
                node_q  <= AW'(half - 1'b1);
                state_q <= S_NODE;
              end
            end
          end
        end
        S_NODE: begin
          state_q <= S_LEFT;
        end
        S_LEFT: begin
          pv_q    <= $signed(rdata);
          state_q <= S_RIGHT;
        end
        S_RIGHT: begin
          lv_q    <= $signed(rdata);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            strobe_q   <= 1'b1;
            kind_q     <= KIND_SWAP;
            first_q    <= pv_q;
            second_q   <= min_val;
            heap_q     <= 1'b0;
            ovf_out_q  <= 1'b0;
            fin_q      <= 1'b0;
            any_swap_q <= 1'b1;
            pick_q     <= pick;
            state_q    <= S_WR;
          end else if (root_q == '0) begin
            state_q <= S_EMIT0;
          end else begin
            root_q  <= root_q - 1'b1;
            node_q  <= root_q - 1'b1;
            state_q <= S_NODE;
          end
        end
        S_WR: begin
          node_q  <= pick_q;
          state_q <= S_NODE;
        end
        S_EMIT0: begin
          idx_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          strobe_q  <= 1'b1;
          kind_q    <= KIND_ELEM;
          first_q   <= $signed(rdata);
          second_q  <= '0;
          heap_q    <= 1'b0;
          ovf_out_q <= 1'b0;
          fin_q     <= 1'b0;
          if (emit_last) begin
            in_verdict_q <= 1'b1;
            state_q      <= S_LOAD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
      // verdict closes the run and clears the run state
      if (in_verdict_q) begin
        strobe_q   <= 1'b1;
        kind_q     <= KIND_VERDICT;
        first_q    <= '0;
        second_q   <= '0;
        heap_q     <= !any_swap_q;
        ovf_out_q  <= ovf_q;
        fin_q      <= 1'b1;
        count_q    <= '0;
        any_swap_q <= 1'b0;
        ovf_q      <= 1'b0;
      end
    end
  end

  assign busy_o         = (state_q != S_LOAD) || in_verdict_q;
  assign strobe_o       = strobe_q;
  assign kind_o         = kind_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign already_heap_o = heap_q;
  assign overflowed_o   = ovf_out_q;
  assign final_result_o = fin_q;

endmodule
`default_nettype wire

FILE: rtl/core/mhb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module mhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: tb/tb_min_heap_builder.sv
`timescale 1ns / 1ps
// self-checking testbench for min_heap_builder with a heap build predictor
module tb_min_heap_builder;
  import mhb_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int ITEM_GOAL = 330;
  localparam int TAIL_CYCLES = 64;

  typedef logic signed [DATA_W-1:0] elem_t;

  localparam elem_t MAX_V = 32'sh7fff_ffff;
  localparam elem_t MIN_V = 32'sh8000_0000;

  typedef struct packed {
    kind_e kind;
    elem_t first;
    elem_t second;
    logic  already_heap;
    logic  overflowed;
    logic  final_result;
  } heap_result_t;

  class heap_scoreboard;
    elem_t        store[CAPACITY];
    int           count;
    bit           any_swap;
    bit           overflow_seen;
    heap_result_t expected_results[$];
    int           errors;
    int           swaps_seen;
    int           verdicts_seen;
    int           heaps_already;
    int           overflow_runs;

    function void push_result(kind_e k, elem_t a, elem_t b, logic ah, logic ovf, logic fin);
      heap_result_t r;
      r.kind = k;
      r.first = a;
      r.second = b;
      r.already_heap = ah;
      r.overflowed = ovf;
      r.final_result = fin;
      expected_results.push_back(r);
    endfunction

    // sift one node down, logging each exchange before it is made
    function void sift_node(int node, int n);
      int    l;
      int    r;
      int    pick;
      elem_t tmp;
      while (node < n) begin
        l = 2 * node + 1;
        r = 2 * node + 2;
        pick = node;
        if (l < n && store[l] < store[node]) pick = l;
        // strict compare keeps the left child on a tie
        if (r < n && store[r] < store[pick]) pick = r;
        if (pick == node) break;
        push_result(KIND_SWAP, store[node], store[pick], 1'b0, 1'b0, 1'b0);
        any_swap = 1'b1;
        tmp = store[node];
        store[node] = store[pick];
        store[pick] = tmp;
        node = pick;
      end
    endfunction

    function void note_element(elem_t v, logic last);
      int n;
      if (count < CAPACITY) begin
        store[count] = v;
        count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!last) return;
      n = count;
      for (int i = n / 2; i > 0; i--) sift_node(i - 1, n);
      for (int i = 0; i < n; i++) push_result(KIND_ELEM, store[i], '0, 1'b0, 1'b0, 1'b0);
      push_result(KIND_VERDICT, '0, '0, !any_swap, overflow_seen, 1'b1);
      count = 0;
      any_swap = 1'b0;
      overflow_seen = 1'b0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [KIND_W-1:0] kind, elem_t first, elem_t second,
                      logic ah, logic ovf, logic fin);
      heap_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d first %0d", kind, first));
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (first !== want.first)
        report_mismatch($sformatf("first_value %0d, want %0d", first, want.first));
      if (second !== want.second)
        report_mismatch($sformatf("second_value %0d, want %0d", second, want.second));
      if (ah !== want.already_heap)
        report_mismatch($sformatf("already_heap %b, want %b", ah, want.already_heap));
      if (ovf !== want.overflowed)
        report_mismatch($sformatf("overflowed %b, want %b", ovf, want.overflowed));
      if (fin !== want.final_result)
        report_mismatch($sformatf("final_result %b, want %b", fin, want.final_result));
      if (want.kind == KIND_SWAP) swaps_seen++;
      if (want.kind == KIND_VERDICT) begin
        verdicts_seen++;
        if (want.already_heap) heaps_already++;
        if (want.overflowed) overflow_runs++;
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic               final_item_i = 1'b0;
  logic               busy_o;
  logic               strobe_o;
  logic [KIND_W-1:0]  kind_o;
  logic signed [DATA_W-1:0] first_value_o;
  logic signed [DATA_W-1:0] second_value_o;
  logic               already_heap_o;
  logic               overflowed_o;
  logic               final_result_o;

  heap_scoreboard sb;
  int items_sent;
  int arrays_sent;

  min_heap_builder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .final_item_i   (final_item_i),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .already_heap_o (already_heap_o),
    .overflowed_o   (overflowed_o),
    .final_result_o (final_result_o)
  );

  always #2 clk_i = ~clk_i;

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1)
      sb.check_result(kind_o, first_value_o, second_value_o,
                      already_heap_o, overflowed_o, final_result_o);
  end

  task automatic drive_element(input elem_t v, input logic last, input bit allow_idle);
    start_i <= 1'b1;
    value_i <= v;
    final_item_i <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_element(v, last);
    items_sent++;
    if (allow_idle && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drive_array(input elem_t arr[$], input bit allow_idle);
    foreach (arr[i]) drive_element(arr[i], i == arr.size() - 1, allow_idle);
    arrays_sent++;
  endtask

  // hold the sender off until every expected result has arrived
  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_array(input bit allow_idle);
    elem_t arr[$];
    int    len;
    int    mode;
    int    pick;
    int    base;
    pick = $urandom_range(99);
    if (pick < 10) len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
    else if (pick < 22) len = CAPACITY;
    else if (pick < 32) len = $urandom_range(1, 2);
    else len = $urandom_range(3, CAPACITY - 1);
    mode = $urandom_range(5);
    base = $urandom_range(2000) - 1000;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0, 1: arr.push_back(elem_t'($urandom));
        2: arr.push_back(elem_t'($urandom_range(6)) - 3);
        3: begin
          // ascending input is already a heap
          base += $urandom_range(2);
          arr.push_back(elem_t'(base));
        end
        4: begin
          base -= $urandom_range(2);
          arr.push_back(elem_t'(base));
        end
        default: begin
          case ($urandom_range(4))
            0: arr.push_back(MIN_V);
            1: arr.push_back(MAX_V);
            2: arr.push_back(-1);
            3: arr.push_back(0);
            default: arr.push_back(1);
          endcase
        end
      endcase
    end
    drive_array(arr, allow_idle);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed arrays: lone element, extremes, ties, sorted and reversed input
    drive_array('{MIN_V}, 1'b1);
    drive_array('{MAX_V, MIN_V}, 1'b1);
    drive_array('{MIN_V, -1, 0, MAX_V}, 1'b1);
    drive_array('{5, 3, 3}, 1'b1);
    drive_array('{5, 5, 5}, 1'b1);
    drive_array('{7, 6, 5, 4, 3, 2, 1}, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      // a stretch of back-to-back transactions with no idling
      random_array(!(arrays_sent >= 12 && arrays_sent < 22));
      if (arrays_sent == 9) drain_results();
    end

    drain_results();
    $display("covered %0d arrays from %0d elements: %0d swaps, %0d already heaps",
             arrays_sent, items_sent, sb.swaps_seen, sb.heaps_already);
    $display("%0d verdicts checked, %0d with dropped elements, %0d mismatches",
             sb.verdicts_seen, sb.overflow_runs, sb.errors);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", sb.expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
